// ===== rtl/core/segment_clamped_window_mean_macros.svh =====
// ----------------------------------------------------------------------------
// segment_clamped_window_mean assertion macros
// Shared concurrent checks; clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CLAMPED_WINDOW_MEAN_MACROS_SVH
`define SEGMENT_CLAMPED_WINDOW_MEAN_MACROS_SVH

// cond holds on every clock out of reset
`define SCWM_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("scwm invariant violated");

// cons holds in the same cycle as ante
`define SCWM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scwm same-cycle check failed");

// cons holds in the cycle after ante
`define SCWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scwm next-cycle check failed");

`endif

// ===== rtl/core/scwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwm_pkg
// Shared constants and types of the segment clamped window mean block.
// ----------------------------------------------------------------------------
package scwm_pkg;

    // default build configuration
    localparam int MAX_HALF_WIDTH_DEF = 32;
    localparam int SAMPLE_BITS_DEF    = 24;

    // width of the half width configuration register
    localparam int HALF_WIDTH_BITS = 6;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/core/segment_clamped_window_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_clamped_window_mean
// Moving average over segmented samples with the window clipped at segment
// edges and divided by its true sample count.
// ----------------------------------------------------------------------------
// Timing: an item that causes no result is accepted in the idle state and
// added to the window in the update state. Each result holds the sequencer in
// the serial divider, one quotient bit a cycle, until the quotient is done.
// Every further result of the flush run at a segment end starts the divider
// from the flush state, and every sample that leaves the window during the
// flush is first read from the sample ring, then subtracted. A stalled output
// holds the sequencer in the divide state. The next beat is taken once the
// last result of an item sits in the output register. The half width is
// sampled at the first sample of each segment; there is no clearing pass
// after reset.
module segment_clamped_window_mean import scwm_pkg::*; #(
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [HALF_WIDTH_BITS-1:0] cfg_data,
    // input samples
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [SAMPLE_BITS-1:0]     sample,
    input  logic                       segment_end,
    // results
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [SAMPLE_BITS-1:0]     mean,
    output logic                       segment_last,
    output logic                       run_last
);

`include "segment_clamped_window_mean_macros.svh"

    localparam int WIN_MAX    = 2 * MAX_HALF_WIDTH;
    localparam int AW         = $clog2(WIN_MAX);
    localparam int RING_DEPTH = 1 << AW;
    localparam int CW         = $clog2(WIN_MAX + 1);
    localparam int HW         = $clog2(MAX_HALF_WIDTH + 1);
    localparam int SUM_W      = SAMPLE_BITS + AW;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] S_UPD   = 3'd1;
    localparam logic [ST_W-1:0] S_FLUSH = 3'd2;
    localparam logic [ST_W-1:0] S_SUB   = 3'd3;
    localparam logic [ST_W-1:0] S_DIV   = 3'd4;

    // control state
    logic [ST_W-1:0]            state_reg,  state_next;
    logic [HALF_WIDTH_BITS-1:0] half_width_reg;
    logic [HW-1:0]              h_reg,      h_next;
    logic [CW-1:0]              seen_reg,   seen_next;
    logic [SUM_W-1:0]           sum_reg,    sum_next;
    logic [AW-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [HW-1:0]              k_reg,      k_next;
    logic [CW-1:0]              cur_reg,    cur_next;
    logic                       last_reg,   last_next;
    logic                       seg_pend_reg, seg_pend_next;
    logic                       run_pend_reg, run_pend_next;
    logic                       out_valid_reg;

    // payload
    logic [SAMPLE_BITS-1:0]     sample_reg;
    logic [SAMPLE_BITS-1:0]     mean_reg;
    logic                       seg_last_reg;
    logic                       run_last_reg;

    // ring and divider
    logic                       ring_we;
    logic [AW-1:0]              ring_raddr;
    logic [SAMPLE_BITS-1:0]     ring_rdata;
    logic                       div_start;
    logic [SUM_W-1:0]           div_dividend;
    logic [CW-1:0]              div_divisor;
    logic [SUM_W-1:0]           div_quotient;
    div_stat_t                  div_stat;

    // combinational helpers
    logic                       in_fire;
    logic [HW-1:0]              h_cfg;
    logic [HW-1:0]              h_eff;
    logic [CW-1:0]              two_h_eff;
    logic [CW-1:0]              two_h;
    logic                       drop;
    logic [SUM_W-1:0]           sum_upd;
    logic [CW-1:0]              n_cnt;
    logic [CW-1:0]              wcount;
    logic [HW-1:0]              h_m1;
    logic [HW-1:0]              offset;
    logic                       emit_now;
    logic [CW-1:0]              kh;
    logic [CW-1:0]              c_val;
    logic                       out_free;
    logic                       load_out;
    logic                       more_flush;
    logic                       finish_seg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= HALF_WIDTH_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_width_reg <= cfg_data;
        end
    end

    // clamp the programmed half width to 1..MAX_HALF_WIDTH
    always_comb
    begin
        if (half_width_reg == '0)
        begin
            h_cfg = HW'(1);
        end
        else if ({1'b0, half_width_reg} > (HALF_WIDTH_BITS + 1)'(MAX_HALF_WIDTH))
        begin
            h_cfg = HW'(MAX_HALF_WIDTH);
        end
        else
        begin
            h_cfg = HW'(half_width_reg);
        end
    end

    // window arithmetic
    always_comb
    begin
        h_eff     = (seen_reg == '0) ? h_cfg : h_reg;
        two_h_eff = CW'({h_eff, 1'b0});
        two_h     = CW'({h_reg, 1'b0});
        drop      = (seen_reg >= two_h);
        sum_upd   = sum_reg + SUM_W'(sample_reg)
                  - (drop ? SUM_W'(ring_rdata) : SUM_W'(0));
        n_cnt     = (seen_reg == CW'(WIN_MAX)) ? seen_reg : seen_reg + CW'(1);
        wcount    = (n_cnt < two_h) ? n_cnt : two_h;
        h_m1      = h_reg - HW'(1);
        offset    = (n_cnt < CW'(h_m1)) ? HW'(n_cnt) : h_m1;
        emit_now  = (n_cnt >= CW'(h_reg));
        kh        = CW'(k_reg) + CW'(h_reg);
        c_val     = (kh > seen_reg) ? seen_reg : kh;
    end

    // ring read address: the leaving sample at accept, flush samples later
    always_comb
    begin
        if (state_reg == S_FLUSH)
        begin
            ring_raddr = wr_ptr_reg - AW'(cur_reg);
        end
        else
        begin
            ring_raddr = wr_ptr_reg - AW'(two_h_eff);
        end
    end

    assign ring_we = (state_reg == S_UPD);

    // output register handoff
    assign out_free   = !out_valid_reg || out_ready;
    assign load_out   = (state_reg == S_DIV) && div_stat.done && out_free;
    assign more_flush = last_reg && (k_reg != '0);
    assign finish_seg = load_out && !more_flush && last_reg;

    // divider request
    always_comb
    begin
        div_dividend = (state_reg == S_UPD) ? sum_upd : sum_reg;
        div_divisor  = (state_reg == S_UPD) ? wcount : c_val;
        div_start    = 1'b0;
        if (state_reg == S_UPD)
        begin
            div_start = emit_now;
        end
        else if (state_reg == S_FLUSH)
        begin
            div_start = (cur_reg == c_val);
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        h_next        = h_reg;
        seen_next     = seen_reg;
        sum_next      = sum_reg;
        wr_ptr_next   = wr_ptr_reg;
        k_next        = k_reg;
        cur_next      = cur_reg;
        last_next     = last_reg;
        seg_pend_next = seg_pend_reg;
        run_pend_next = run_pend_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    h_next     = h_eff;
                    last_next  = segment_end;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                sum_next      = sum_upd;
                wr_ptr_next   = wr_ptr_reg + AW'(1);
                seen_next     = n_cnt;
                cur_next      = wcount;
                k_next        = offset;
                seg_pend_next = last_reg && (h_reg == HW'(1));
                run_pend_next = !last_reg || (offset == '0);
                if (emit_now)
                begin
                    state_next = S_DIV;
                end
                else if (last_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (cur_reg == c_val)
                begin
                    seg_pend_next = (k_reg == HW'(1));
                    run_pend_next = (k_reg == HW'(1));
                    k_next        = k_reg - HW'(1);
                    state_next    = S_DIV;
                end
                else
                begin
                    cur_next   = cur_reg - CW'(1);
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                sum_next   = sum_reg - SUM_W'(ring_rdata);
                state_next = S_FLUSH;
            end
            S_DIV:
            begin
                if (load_out)
                begin
                    if (more_flush)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        if (last_reg)
                        begin
                            seen_next = '0;
                            sum_next  = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            h_reg        <= HW'(1);
            seen_reg     <= '0;
            sum_reg      <= '0;
            wr_ptr_reg   <= '0;
            k_reg        <= '0;
            cur_reg      <= '0;
            last_reg     <= 1'b0;
            seg_pend_reg <= 1'b0;
            run_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            h_reg        <= h_next;
            seen_reg     <= seen_next;
            sum_reg      <= sum_next;
            wr_ptr_reg   <= wr_ptr_next;
            k_reg        <= k_next;
            cur_reg      <= cur_next;
            last_reg     <= last_next;
            seg_pend_reg <= seg_pend_next;
            run_pend_reg <= run_pend_next;
        end
    end

    // input beat payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= sample;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            mean_reg     <= div_quotient[SAMPLE_BITS-1:0];
            seg_last_reg <= seg_pend_reg;
            run_last_reg <= run_pend_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mean         = mean_reg;
    assign segment_last = seg_last_reg;
    assign run_last     = run_last_reg;

    // sample ring
    scwm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wr_ptr_reg),
        .wdata (sample_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // serial divider
    scwm_div #(
        .DVD_W (SUM_W),
        .DVS_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // checks
    `SCWM_ASSERT_ALWAYS(a_h_range, (h_reg >= HW'(1)) && (h_reg <= HW'(MAX_HALF_WIDTH)))
    `SCWM_ASSERT_IMPLIES(a_load_after_div, load_out, div_stat.done && !div_stat.busy)
    `SCWM_ASSERT_IMPLIES(a_flush_no_undershoot, state_reg == S_FLUSH, cur_reg >= c_val)
    `SCWM_ASSERT_NEXT(a_segment_cleared, finish_seg, (seen_reg == '0) && (sum_reg == '0))

endmodule

// ===== rtl/core/scwm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module scwm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/scwm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwm_div
// Radix-2 restoring divider, one quotient bit per cycle, quotient held
// until the next start.
// ----------------------------------------------------------------------------
module scwm_div import scwm_pkg::*; #(
    parameter int DVD_W = 30,
    parameter int DVS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output div_stat_t        stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   rem_sh;
    logic             ge;
    logic [DVS_W:0]   rem_sub;

    // one restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DVD_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
